// ===== hw/rtl/sefe_pkg.sv =====
// Shared types and byte codes for the serial EEPROM command frame engine.
`default_nettype none

package sefe_pkg;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_APPEND,
    ST_COMMIT,
    ST_RESP
  } sefe_state_t;

  localparam logic [7:0] SOF_BYTE    = 8'h7B;
  localparam logic [7:0] EOF_BYTE    = 8'h7D;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  localparam logic [7:0] OP_READ   = 8'hAA;
  localparam logic [7:0] OP_WRITE  = 8'hBB;
  localparam logic [7:0] OP_PSTART = 8'hCC;
  localparam logic [7:0] OP_PDATA  = 8'hCD;

  // Frame body bytes after the start byte: command, address low, address high, data.
  localparam logic [2:0] FRAME_BODY = 3'd4;
  localparam logic [1:0] FB_CMD     = 2'd0;
  localparam logic [1:0] FB_ALO     = 2'd1;
  localparam logic [1:0] FB_AHI     = 2'd2;
  localparam logic [1:0] FB_DATA    = 2'd3;

  // Response beats.
  localparam logic [1:0] BEAT_SOF = 2'd0;
  localparam logic [1:0] BEAT_VAL = 2'd1;
  localparam logic [1:0] BEAT_INV = 2'd2;
  localparam logic [1:0] BEAT_EOF = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/sefe_ram.sv =====
// Single-port-write, single-port-read byte RAM with registered read data.
`default_nettype none

module sefe_ram
  import sefe_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/serial_eeprom_command_frame_engine_unit.sv =====
// Serial EEPROM command frame engine: frame parser, memory, page buffer, responder.
//
// Input channel: one received byte per request (in_valid, in_stall, in_rx_byte).
// Bytes outside a frame are dropped until the start byte 0x7B appears; a frame is
// start, command, address low, address high, data, end (0x7D). A frame with a bad
// end byte is dropped without a response.
// Result channel: four response bytes per good frame (start, value, inverted value,
// end), with out_response_last high on the fourth.
// Timing: a byte that does not close a frame is taken without a stall, so such bytes can
// arrive back to back. A closing byte is followed by extra work before the response:
// none for write, page start and echo, a registered memory read for a read, one
// buffer write per appended byte for page data (address low, address high, data), and
// a copy of the buffer into memory one byte per cycle when that frame fills the page.
// in_stall stays high from the closing byte until the last response byte is taken.
// Reset: a clearing pass writes 0xFF to every one of the 2^ADDR_BITS memory bytes
// (65536 by default), with in_stall high throughout; then the block hunts.
// When the receiver stalls, the current response byte is held unchanged.
`default_nettype none

module serial_eeprom_command_frame_engine_unit
  import sefe_pkg::*;
#(
  parameter int PAGE_BYTES = 256,
  parameter int ADDR_BITS  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_tx_byte,
  output logic            out_response_last
);

  localparam int PB_IW     = $clog2(PAGE_BYTES);
  localparam int PF_W      = $clog2(PAGE_BYTES + 1);
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [PF_W-1:0] PAGE_FULL = PF_W'(PAGE_BYTES);

  sefe_state_t            state_r, state_nxt;
  logic                   hunting_r, hunting_nxt;
  logic [2:0]             fcnt_r, fcnt_nxt;
  logic [7:0]             fb_r [4];
  logic [ADDR_BITS-1:0]   base_r, base_nxt;
  logic [PF_W-1:0]        fill_r, fill_nxt;
  logic [7:0]             val_r, val_nxt;
  logic [1:0]             app_cnt_r, app_cnt_nxt;
  logic                   before_full_r, before_full_nxt;
  logic [PF_W-1:0]        ccnt_r, ccnt_nxt;
  logic [1:0]             beat_r, beat_nxt;
  logic [ADDR_BITS-1:0]   clr_addr_r, clr_addr_nxt;

  logic                   in_acc, out_acc, end_ok, fill_room;
  logic [7:0]             cmd, alo, ahi, dat, app_byte;
  logic [ADDR_BITS-1:0]   faddr;

  logic                   mem_we;
  logic [ADDR_BITS-1:0]   mem_waddr;
  logic [7:0]             mem_wdata, mem_rdata;
  logic                   buf_we;
  logic [PB_IW-1:0]       buf_waddr, buf_raddr;
  logic [7:0]             buf_wdata, buf_rdata;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_RESP);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;

  assign cmd   = fb_r[FB_CMD];
  assign alo   = fb_r[FB_ALO];
  assign ahi   = fb_r[FB_AHI];
  assign dat   = fb_r[FB_DATA];
  assign faddr = ADDR_BITS'({ahi, alo});

  assign end_ok    = in_acc && !hunting_r && (fcnt_r == FRAME_BODY) && (in_rx_byte == EOF_BYTE);
  assign fill_room = (fill_r < PAGE_FULL);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (end_ok) begin
          unique case (cmd)
            OP_READ:  state_nxt = ST_READ;
            OP_PDATA: state_nxt = ST_APPEND;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_READ: state_nxt = ST_RESP;
      ST_APPEND: begin
        if (app_cnt_r == FB_AHI) begin
          if (fill_nxt == PAGE_FULL && !before_full_r) state_nxt = ST_COMMIT;
          else                                         state_nxt = ST_RESP;
        end
      end
      ST_COMMIT: begin
        if (ccnt_r == PAGE_FULL) state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_acc && beat_r == BEAT_EOF) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    hunting_nxt     = hunting_r;
    fcnt_nxt        = fcnt_r;
    base_nxt        = base_r;
    fill_nxt        = fill_r;
    val_nxt         = val_r;
    app_cnt_nxt     = app_cnt_r;
    before_full_nxt = before_full_r;
    ccnt_nxt        = '0;
    beat_nxt        = beat_r;
    clr_addr_nxt    = clr_addr_r;
    mem_we          = 1'b0;
    mem_waddr       = faddr;
    mem_wdata       = dat;
    buf_we          = 1'b0;
    buf_waddr       = '0;
    buf_wdata       = dat;
    buf_raddr       = '0;
    app_byte        = alo;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = ERASED_BYTE;
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
      ST_IDLE: begin
        beat_nxt    = BEAT_SOF;
        app_cnt_nxt = '0;
        if (in_acc) begin
          if (hunting_r) begin
            if (in_rx_byte == SOF_BYTE) begin
              hunting_nxt = 1'b0;
              fcnt_nxt    = '0;
            end
          end else if (fcnt_r < FRAME_BODY) begin
            fcnt_nxt = fcnt_r + 1'b1;
          end else begin
            hunting_nxt = 1'b1;
            fcnt_nxt    = '0;
          end
        end
        if (end_ok) begin
          val_nxt         = dat;
          before_full_nxt = !fill_room;
          unique case (cmd)
            OP_WRITE: mem_we = 1'b1;
            OP_PSTART: begin
              base_nxt = faddr;
              buf_we   = 1'b1;
              fill_nxt = PF_W'(1);
            end
            default: ;
          endcase
        end
      end
      ST_READ: val_nxt = mem_rdata;
      ST_APPEND: begin
        unique case (app_cnt_r)
          FB_CMD:  app_byte = alo;
          FB_ALO:  app_byte = ahi;
          default: app_byte = dat;
        endcase
        buf_wdata   = app_byte;
        buf_waddr   = fill_r[PB_IW-1:0];
        app_cnt_nxt = app_cnt_r + 1'b1;
        if (fill_room) begin
          buf_we   = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        if (app_cnt_r == FB_AHI) begin
          val_nxt = (fill_nxt == PAGE_FULL) ? ~alo : alo;
        end
      end
      ST_COMMIT: begin
        // Read one buffer byte per cycle; write the previous one from the registered read data.
        ccnt_nxt = ccnt_r + 1'b1;
        if (ccnt_r < PAGE_FULL) buf_raddr = ccnt_r[PB_IW-1:0];
        if (ccnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = base_r + ADDR_BITS'(ccnt_r - PF_W'(1));
          mem_wdata = buf_rdata;
        end
      end
      ST_RESP: begin
        if (out_acc) beat_nxt = beat_r + 1'b1;
      end
      default: ;
    endcase
  end

  // Response byte, chosen from registered state only.
  always_comb begin
    out_response_last = (beat_r == BEAT_EOF);
    unique case (beat_r)
      BEAT_SOF: out_tx_byte = SOF_BYTE;
      BEAT_VAL: out_tx_byte = val_r;
      BEAT_INV: out_tx_byte = ~val_r;
      default:  out_tx_byte = EOF_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      hunting_r  <= 1'b1;
      fcnt_r     <= '0;
      base_r     <= '0;
      fill_r     <= '0;
      app_cnt_r  <= '0;
      ccnt_r     <= '0;
      beat_r     <= BEAT_SOF;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      hunting_r  <= hunting_nxt;
      fcnt_r     <= fcnt_nxt;
      base_r     <= base_nxt;
      fill_r     <= fill_nxt;
      app_cnt_r  <= app_cnt_nxt;
      ccnt_r     <= ccnt_nxt;
      beat_r     <= beat_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r         <= val_nxt;
    before_full_r <= before_full_nxt;
    if (in_acc && !hunting_r && fcnt_r < FRAME_BODY) begin
      fb_r[fcnt_r[1:0]] <= in_rx_byte;
    end
  end

  sefe_ram #(
    .DEPTH (MEM_DEPTH),
    .AW    (ADDR_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (faddr),
    .rdata_r (mem_rdata)
  );

  sefe_ram #(
    .DEPTH (PAGE_BYTES),
    .AW    (PB_IW)
  ) u_page (
    .clk     (clk),
    .we      (buf_we),
    .waddr   (buf_waddr),
    .wdata   (buf_wdata),
    .raddr   (buf_raddr),
    .rdata_r (buf_rdata)
  );

  // The page fill count never runs past the page size.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PAGE_FULL)
    else $error("page fill count exceeds page size");

  // A copy into memory only runs on a full page that was not full before the frame.
  a_commit_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMMIT) |-> (fill_r == PAGE_FULL && !before_full_r))
    else $error("page copy started on a page that is not newly full");

  // Taking the last response byte reopens the input channel on the next cycle.
  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_response_last) |=> !in_stall)
    else $error("input not reopened after response");

  // A closing byte with a good end marker always leads to a response, never straight back.
  a_end_resp: assert property (@(posedge clk) disable iff (!rst_n)
    end_ok |=> in_stall)
    else $error("good frame accepted without starting work");

  // No response is presented while the memory is being erased.
  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (!out_valid && in_stall))
    else $error("channel active during erase");

endmodule

`default_nettype wire
